/* sv/rsst_pkg.sv */
package rsst_pkg;

    // Fixed field widths of the stream words.
    localparam int POS_W       = 10;
    localparam int VAL_W       = 32;
    localparam int SUM_W       = 64;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 64;

    typedef logic signed [SUM_W-1:0] t_sum;

    // Controller states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SET,
        ST_Q_LO,
        ST_Q_HI,
        ST_OUT
    } t_state;

    // Kinds of input word, carried in the input tuser.
    typedef enum logic {
        FN_SET   = 1'b0,
        FN_QUERY = 1'b1
    } t_func;

    // One finished query result.
    typedef struct packed {
        t_sum range_sum;
        logic bad_range;
    } t_result;

endpackage

/* sv/rsst_node_mem.sv */
module rsst_node_mem #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  rsst_pkg::t_sum i_wdata,
    input  logic [AW-1:0] i_raddr,
    output rsst_pkg::t_sum o_rdata
);
    import rsst_pkg::*;

    t_sum r_ram [0:DEPTH-1];
    t_sum r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_ram[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_ram[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/rsst_ctrl.sv */
module rsst_ctrl #(
    parameter int CAPACITY = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_func,
    input  logic [rsst_pkg::POS_W-1:0]    i_first_pos,
    input  logic [rsst_pkg::POS_W-1:0]    i_last_pos,
    input  logic signed [rsst_pkg::VAL_W-1:0] i_new_value,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output rsst_pkg::t_result             o_res,
    output logic                          o_mem_we,
    output logic [$clog2(2*CAPACITY)-1:0] o_mem_waddr,
    output rsst_pkg::t_sum                o_mem_wdata,
    output logic [$clog2(2*CAPACITY)-1:0] o_mem_raddr,
    input  rsst_pkg::t_sum                i_mem_rdata
);
    import rsst_pkg::*;

    localparam int DEPTH = 2 * CAPACITY;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = AW + 1;
    localparam int CW    = ((IW > POS_W + 1) ? IW : POS_W + 1) + 1;

    t_state         r_state, n_state;
    logic [AW-1:0]  r_clr_idx, n_clr_idx;
    logic [IW-1:0]  r_idx, n_idx;
    logic [IW-1:0]  r_lo, n_lo;
    logic [IW-1:0]  r_hi, n_hi;
    logic           r_pend, n_pend;
    logic           r_bad, n_bad;
    t_sum           r_acc, n_acc;

    logic           w_accept;
    logic           w_clr_last;
    logic [CW-1:0]  w_first_ext;
    logic [CW-1:0]  w_last_ext;
    logic [CW-1:0]  w_cap;
    logic [CW-1:0]  w_last_cl;
    logic           w_set_skip;
    logic           w_q_rev;
    logic           w_q_above;
    logic [IW-1:0]  w_leaf;
    logic [IW-1:0]  w_parent;
    logic           w_lo_lt_hi;
    t_sum           w_value_ext;
    t_sum           w_acc_in;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_clr_last  = (r_clr_idx == AW'(DEPTH - 1));
    assign w_first_ext = CW'(i_first_pos);
    assign w_last_ext  = CW'(i_last_pos);
    assign w_cap       = CW'(CAPACITY);
    assign w_last_cl   = (w_last_ext >= w_cap) ? (w_cap - CW'(1)) : w_last_ext;
    assign w_set_skip  = (w_first_ext >= w_cap);
    assign w_q_rev     = (i_first_pos > i_last_pos);
    assign w_q_above   = (w_first_ext >= w_cap);
    assign w_leaf      = IW'(w_first_ext + w_cap);
    assign w_parent    = r_idx >> 1;
    assign w_lo_lt_hi  = (r_lo < r_hi);
    assign w_value_ext = {{(SUM_W - VAL_W){i_new_value[VAL_W-1]}}, i_new_value};
    assign w_acc_in    = r_acc + (r_pend ? i_mem_rdata : '0);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (w_clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_func == FN_SET) begin
                        n_state = w_set_skip ? ST_IDLE : ST_SET;
                    end else if (w_q_rev || w_q_above) begin
                        n_state = ST_OUT;
                    end else begin
                        n_state = ST_Q_LO;
                    end
                end
            end
            ST_SET: begin
                if (w_parent == IW'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_Q_LO: begin
                n_state = w_lo_lt_hi ? ST_Q_HI : ST_OUT;
            end
            ST_Q_HI: begin
                n_state = ST_Q_LO;
            end
            ST_OUT: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // Datapath and memory port control.
    always_comb begin
        n_clr_idx   = r_clr_idx;
        n_idx       = r_idx;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_pend      = r_pend;
        n_bad       = r_bad;
        n_acc       = r_acc;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_clr_idx;
        o_mem_wdata = '0;
        o_mem_raddr = '0;
        o_res_valid = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_mem_we  = 1'b1;
                n_clr_idx = r_clr_idx + AW'(1);
            end
            ST_IDLE: begin
                n_pend = 1'b0;
                if (w_accept) begin
                    if (i_func == FN_SET) begin
                        // Leaf write now, sibling read for the first parent.
                        o_mem_we    = !w_set_skip;
                        o_mem_waddr = AW'(w_leaf);
                        o_mem_wdata = w_value_ext;
                        o_mem_raddr = AW'(w_leaf ^ IW'(1));
                        n_idx       = w_leaf;
                        n_acc       = w_value_ext;
                    end else begin
                        n_acc = '0;
                        n_bad = w_q_rev;
                        n_lo  = IW'(w_first_ext + w_cap);
                        n_hi  = IW'(w_last_cl + w_cap + CW'(1));
                    end
                end
            end
            ST_SET: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = AW'(w_parent);
                o_mem_wdata = r_acc + i_mem_rdata;
                o_mem_raddr = AW'(w_parent ^ IW'(1));
                n_acc       = r_acc + i_mem_rdata;
                n_idx       = w_parent;
            end
            ST_Q_LO: begin
                n_acc  = w_acc_in;
                n_pend = 1'b0;
                if (w_lo_lt_hi) begin
                    o_mem_raddr = AW'(r_lo);
                    n_pend      = r_lo[0];
                    n_lo        = r_lo + IW'(r_lo[0]);
                end
            end
            ST_Q_HI: begin
                n_acc       = w_acc_in;
                o_mem_raddr = AW'(r_hi - IW'(1));
                n_pend      = r_hi[0];
                n_hi        = (r_hi - IW'(r_hi[0])) >> 1;
                n_lo        = r_lo >> 1;
            end
            ST_OUT: begin
                o_res_valid = 1'b1;
            end
            default: begin
                n_pend = 1'b0;
            end
        endcase
    end

    assign o_res.range_sum = r_acc;
    assign o_res.bad_range = r_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_idx <= '0;
            r_pend    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_idx <= n_clr_idx;
            r_pend    <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_bad <= n_bad;
        r_acc <= n_acc;
    end

endmodule

/* sv/range_sum_segment_tree.sv */
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: first_pos, last_pos, new_value
//                                              tuser: func
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: range_sum; tuser: bad_range
//
// A set word writes the leaf in the accepting cycle, then for each tree level
// adds the sibling read from the node memory and writes the parent. A query
// is set up in the accepting cycle, then walks the levels, the single read
// port of the node memory serving the left and the right edge of the range in
// alternate cycles; a closing step adds the last read and a final step hands
// the result to the output register. A full range walks log2(CAPACITY) + 1 levels.
// After reset the node memory is cleared, one entry per cycle, over all
// 2 * CAPACITY entries, with s_axis_tready held low. A finished result sits in
// the output register, so the next word is accepted while it waits; a later
// query stalls only when it finishes before that register has been drained.
module range_sum_segment_tree #(
    parameter int CAPACITY = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [9:0] first_pos, [19:10] last_pos, [51:20] new_value, [55:52] zero
    input  logic [rsst_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // [0] func
    input  logic [0:0]                         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [63:0] range_sum
    output logic [rsst_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // [0] bad_range
    output logic [0:0]                         m_axis_tuser
);
    import rsst_pkg::*;

    localparam int DEPTH = 2 * CAPACITY;
    localparam int AW    = $clog2(DEPTH);

    logic          w_mem_we;
    logic [AW-1:0] w_mem_waddr;
    t_sum          w_mem_wdata;
    logic [AW-1:0] w_mem_raddr;
    t_sum          w_mem_rdata;

    logic          w_res_valid;
    logic          w_res_ready;
    t_result       w_res;

    logic          r_m_valid;
    t_result       r_m_res;

    // The node memory holds every partial sum; node 1 is the root and
    // element p lives in leaf CAPACITY + p.
    rsst_node_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    // The controller walks the tree one level (set) or one half level (query)
    // per cycle, and runs the clearing sweep after reset.
    rsst_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_func      (s_axis_tuser[0]),
        .i_first_pos (s_axis_tdata[9:0]),
        .i_last_pos  (s_axis_tdata[19:10]),
        .i_new_value (s_axis_tdata[51:20]),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res),
        .o_mem_we    (w_mem_we),
        .o_mem_waddr (w_mem_waddr),
        .o_mem_wdata (w_mem_wdata),
        .o_mem_raddr (w_mem_raddr),
        .i_mem_rdata (w_mem_rdata)
    );

    // Output register: it takes a new result whenever it is empty or is
    // being emptied in the same cycle.
    assign w_res_ready = !r_m_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_m_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_m_res <= w_res;
        end
    end

    assign m_axis_tvalid   = r_m_valid;
    assign m_axis_tdata    = r_m_res.range_sum;
    assign m_axis_tuser[0] = r_m_res.bad_range;

    // A reversed range always reports a zero sum.
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("reversed range returned a nonzero sum");

    // The clearing sweep keeps the input closed right after reset.
    a_clear_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !s_axis_tready)
        else $error("input opened before the node memory was cleared");

    // A set word never produces a result in the next cycle.
    a_set_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == FN_SET))
            |=> !w_res_valid)
        else $error("set word produced a result");

    // The output register is never overwritten while it still holds a word.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("pending result was overwritten");

endmodule
